// ===== src/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned TotalW = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } entry_t;

  typedef struct packed {
    logic                     operation;
    logic signed [ValueW-1:0] item_value;
    logic [PrioW-1:0]         item_priority;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] popped_value;
    logic [PrioW-1:0]         popped_priority;
    logic [1:0]               status;
    logic [TotalW-1:0]        entry_total;
    logic                     is_empty;
    logic [PrioW-1:0]         head_priority;
  } rsp_t;

endpackage

// ===== src/spq_mem.sv =====
module spq_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  spq_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output spq_pkg::entry_t     rdata_o
);

  spq_pkg::entry_t mem_q [Depth];
  spq_pkg::entry_t rdata_q;

  // one write port, one read port with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sorted_priority_queue.sv =====
// sorted priority queue, up to QUEUE_DEPTH entries of 32-bit value and 16-bit priority
//
// usage: drive req_i and raise start while busy is low; the request is taken at that
// edge. req_i.operation selects insert or pop. exactly one result per request comes
// back on rsp_o, marked by done_o for a single cycle; the receiver cannot stall it.
// a new request may be issued in the same cycle that done_o is high.
//
// entries sit in one ram ordered by descending priority, head at address 0, equal
// priorities first in, first out. one compare unit and the single ram port pair do
// all the work under a small sequencer:
//   insert walks from the tail toward the head, one read and one compare/move per
//   entry passed, moving back every entry of lower priority; when all move, the
//   new entry is written at the head; done_o is registered after the last step
//   pop reads the head, then moves every other entry up one slot, one per cycle
//   full insert or empty pop answers straight from idle with the matching status
// the ram port (one read, one write per cycle) paces these steps.
//
// reset clears the count, the head priority and the sequencer; ram contents are
// left as they are and only addresses below the count are ever read.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  spq_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output spq_pkg::rsp_t rsp_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_INS_PUT  = 3'd3;
  localparam logic [2:0] S_POP_HEAD = 3'd4;
  localparam logic [2:0] S_POP_MV   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   count_q, count_d;
  logic [spq_pkg::PrioW-1:0] head_q, head_d;
  spq_pkg::req_t   req_q, req_d;
  spq_pkg::entry_t pop_q, pop_d;
  logic            done_q, done_d;
  spq_pkg::rsp_t   rsp_q, rsp_d;

  // ram port signals
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  spq_pkg::entry_t mem_wdata, mem_rdata;

  // finish of a request
  logic            fin;
  logic [1:0]      fin_stat;
  spq_pkg::entry_t fin_pop;
  spq_pkg::entry_t new_entry;
  logic [CW+4:0]   total_ext;

  spq_mem #(
    .Depth (QUEUE_DEPTH),
    .AddrW (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign new_entry.value = req_q.item_value;
  assign new_entry.prio  = req_q.item_priority;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    head_d    = head_q;
    req_d     = req_q;
    pop_d     = pop_q;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q - IW'(1);
    fin       = 1'b0;
    fin_stat  = spq_pkg::ST_DONE;
    fin_pop   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.operation == spq_pkg::OP_POP) begin
            if (count_q == '0) begin
              fin      = 1'b1;
              fin_stat = spq_pkg::ST_EMPTY;
            end else begin
              // fetch the head
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = IW'(1);
              state_d   = S_POP_HEAD;
            end
          end else begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              fin      = 1'b1;
              fin_stat = spq_pkg::ST_FULL;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_PUT;
            end else begin
              // start at the tail, first free slot
              idx_d   = count_q[IW-1:0];
              state_d = S_INS_RD;
            end
          end
        end
      end

      S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q - IW'(1);
        state_d   = S_INS_CMP;
      end

      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        if (mem_rdata.prio >= req_q.item_priority) begin
          // new entry lands right behind this one
          mem_wdata = new_entry;
          count_d   = count_q + CW'(1);
          fin       = 1'b1;
          state_d   = S_IDLE;
        end else begin
          // move the lower-priority entry back one slot
          mem_wdata = mem_rdata;
          idx_d     = idx_q - IW'(1);
          state_d   = (idx_q == IW'(1)) ? S_INS_PUT : S_INS_RD;
        end
      end

      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = new_entry;
        if (idx_q == '0) begin
          head_d = req_q.item_priority;
        end
        count_d = count_q + CW'(1);
        fin     = 1'b1;
        state_d = S_IDLE;
      end

      S_POP_HEAD: begin
        pop_d = mem_rdata;
        if (count_q == CW'(1)) begin
          count_d = '0;
          head_d  = '0;
          fin     = 1'b1;
          fin_pop = mem_rdata;
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q;
          state_d   = S_POP_MV;
        end
      end

      S_POP_MV: begin
        // move entry up one slot
        mem_we    = 1'b1;
        mem_waddr = idx_q - IW'(1);
        mem_wdata = mem_rdata;
        if (idx_q == IW'(1)) begin
          head_d = mem_rdata.prio;
        end
        if (CW'(idx_q) + CW'(1) == count_q) begin
          count_d = count_q - CW'(1);
          fin     = 1'b1;
          fin_pop = pop_q;
          state_d = S_IDLE;
        end else begin
          idx_d     = idx_q + IW'(1);
          mem_re    = 1'b1;
          mem_raddr = idx_q + IW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // result register, taken from the post-request state
    total_ext = {5'b0, count_d};
    done_d    = fin;
    if (fin) begin
      rsp_d.popped_value    = fin_pop.value;
      rsp_d.popped_priority = fin_pop.prio;
      rsp_d.status          = fin_stat;
      rsp_d.entry_total     = total_ext[spq_pkg::TotalW-1:0];
      rsp_d.is_empty        = (count_d == '0);
      rsp_d.head_priority   = (count_d == '0) ? '0 : head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    pop_q <= pop_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // count never runs past the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // the ram is only written while a request is being worked
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> busy)
    else $error("ram write outside a request");

  // a result always leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // pop on empty answers at once with the empty status
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == spq_pkg::OP_POP && count_q == '0)
      |=> (done_o && rsp_o.status == spq_pkg::ST_EMPTY))
    else $error("empty pop not flagged");

  // empty flag agrees with the stored count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (count_q == '0)))
    else $error("empty flag does not match count");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth      = 16;
  localparam int unsigned CycleLimit = 200000;
  // longest request is an insert into a queue one short of full
  localparam int unsigned SettleCycles = 2 * Depth + 8;
  localparam int unsigned RandomReqs   = 530;

  // one stored entry of the shadow queue
  typedef struct packed {
    logic signed [spq_pkg::ValueW-1:0] value;
    logic [spq_pkg::PrioW-1:0]         prio;
  } slot_t;

  // a request waiting to be sent; hold_for_drain makes the sender wait until
  // every outstanding result has come back before it goes out
  typedef struct {
    spq_pkg::req_t req;
    bit            hold_for_drain;
  } pending_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  spq_pkg::req_t req_i = '0;
  logic busy;
  logic done_o;
  spq_pkg::rsp_t rsp_o;

  pending_t      pending_reqs[$];
  spq_pkg::rsp_t expected_rsp[$];
  slot_t         sorted_slots[$];   // shadow of the queue contents, head first

  int unsigned n_issued   = 0; // requests put on req_i so far
  int unsigned n_accepted = 0; // requests taken by the block so far
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one line per mismatch, and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [spq_pkg::ValueW-1:0] got,
                             input logic [spq_pkg::ValueW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // applies one request to the shadow queue and returns the result it must give
  function automatic spq_pkg::rsp_t apply_queue_request(input spq_pkg::req_t r);
    spq_pkg::rsp_t res;
    slot_t         ent;
    int            pos;
    res = '0;
    if (r.operation == spq_pkg::OP_INSERT) begin
      if (sorted_slots.size() >= Depth) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < sorted_slots.size() && sorted_slots[pos].prio >= r.item_priority) begin
          pos++;
        end
        ent.value = r.item_value;
        ent.prio  = r.item_priority;
        sorted_slots.insert(pos, ent);
        res.status = spq_pkg::ST_DONE;
      end
    end else begin
      if (sorted_slots.size() == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        ent = sorted_slots.pop_front();
        res.popped_value    = ent.value;
        res.popped_priority = ent.prio;
        res.status          = spq_pkg::ST_DONE;
      end
    end
    res.entry_total   = spq_pkg::TotalW'(sorted_slots.size());
    res.is_empty      = (sorted_slots.size() == 0);
    res.head_priority = (sorted_slots.size() == 0) ? '0 : sorted_slots[0].prio;
    return res;
  endfunction

  task automatic add_request(input logic op, input logic [spq_pkg::ValueW-1:0] value,
                             input logic [spq_pkg::PrioW-1:0] prio, input bit hold);
    pending_t p;
    p.req.operation     = op;
    p.req.item_value    = value;
    p.req.item_priority = prio;
    p.hold_for_drain    = hold;
    pending_reqs.push_back(p);
  endtask

  // priorities drawn from a mix: full range, crowded low values for ties,
  // the top of the range, and coarse steps that collide often
  function automatic logic [spq_pkg::PrioW-1:0] pick_priority();
    logic [spq_pkg::PrioW-1:0] p;
    case ($urandom_range(3))
      0: begin
        p = spq_pkg::PrioW'($urandom);
      end
      1: begin
        p = spq_pkg::PrioW'($urandom_range(3));
      end
      2: begin
        p = 16'hFFFF - spq_pkg::PrioW'($urandom_range(2));
      end
      default: begin
        p = {3'($urandom_range(7)), 13'h0000};
      end
    endcase
    return p;
  endfunction

  // sender: changes inputs at the falling edge, holds a request until taken
  always @(negedge clk_i) begin : request_driver
    pending_t nxt;
    logic     go;
    bit       no_idle;
    if (rst_ni) begin
      // a request still on the bus and not yet taken stays as it is
      if (!(start && n_accepted != n_issued)) begin
        go      = 1'b0;
        // a stretch in the middle of the run with back-to-back requests
        no_idle = (n_issued >= 300 && n_issued < 400);
        if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].hold_for_drain && expected_rsp.size() != 0) begin
            go = 1'b0;
          end else if (!no_idle && $urandom_range(99) < 36) begin
            go = 1'b0;
          end else begin
            go = 1'b1;
          end
        end
        if (go) begin
          nxt = pending_reqs.pop_front();
          n_issued++;
          req_i <= nxt.req;
        end
        start <= go;
      end
    end
  end

  // monitor: samples at the rising edge; checks a finished result before
  // predicting for a request taken at the same edge
  always @(posedge clk_i) begin : result_monitor
    spq_pkg::rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: %h", rsp_o));
        end else begin
          want = expected_rsp.pop_front();
          check_field("popped_value", rsp_o.popped_value, want.popped_value);
          check_field("popped_priority", spq_pkg::ValueW'(rsp_o.popped_priority),
                      spq_pkg::ValueW'(want.popped_priority));
          check_field("status", spq_pkg::ValueW'(rsp_o.status),
                      spq_pkg::ValueW'(want.status));
          check_field("entry_total", spq_pkg::ValueW'(rsp_o.entry_total),
                      spq_pkg::ValueW'(want.entry_total));
          check_field("is_empty", spq_pkg::ValueW'(rsp_o.is_empty),
                      spq_pkg::ValueW'(want.is_empty));
          check_field("head_priority", spq_pkg::ValueW'(rsp_o.head_priority),
                      spq_pkg::ValueW'(want.head_priority));
        end
      end
      if (start && !busy) begin
        expected_rsp.push_back(apply_queue_request(req_i));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // watchdog against a hung block
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned mode;
    int          insert_pct;
    logic        op;
    bit          hold;
    // directed part: pop on empty, then fill to the brim with ties and extremes
    add_request(spq_pkg::OP_POP, 32'h1234_5678, 16'hFFFF, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h8000_0000, 16'h0000, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h0000_0000, 16'h8000, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h8000, 1'b0);   // tie behind 8000
    add_request(spq_pkg::OP_INSERT, 32'h0000_0001, 16'h0000, 1'b0);   // tie at the tail
    add_request(spq_pkg::OP_INSERT, 32'hAAAA_AAAA, 16'hFFFF, 1'b0);   // tie at the head
    add_request(spq_pkg::OP_INSERT, 32'h5555_5555, 16'h7FFF, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'hDEAD_BEEF, 16'h0001, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h0BAD_F00D, 16'hFFFE, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'hC0FF_EE00, 16'h8000, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h1111_1111, 16'h5555, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h2222_2222, 16'hAAAA, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h3333_3333, 16'h0000, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h4444_4444, 16'h00FF, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h6666_6666, 16'hFF00, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'h7777_7777, 16'h8001, 1'b0);   // now full
    add_request(spq_pkg::OP_INSERT, 32'h9999_9999, 16'hFFFF, 1'b0);   // refused, full
    repeat (6) add_request(spq_pkg::OP_POP, 32'h0, 16'h0, 1'b0);
    add_request(spq_pkg::OP_INSERT, 32'hFEDC_BA98, 16'h8000, 1'b0);

    // random part: phases that lean toward filling or draining so that both
    // the full and the empty case come up often, with random content throughout
    mode = 0;
    for (int i = 0; i < RandomReqs; i++) begin
      if (i % 40 == 0) begin
        mode = $urandom_range(2);
      end
      insert_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 55;
      op   = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
      hold = (i % 150 == 0);
      add_request(op, spq_pkg::ValueW'($urandom), pick_priority(), hold);
    end

    // reset once at the start
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // everything sent, taken and answered
    while (!(pending_reqs.size() == 0 && n_accepted == n_issued && expected_rsp.size() == 0))
    begin
      @(posedge clk_i);
    end
    // let any stray result show up
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
